/* rtl/shto_pkg.sv */
// Package for the string hash table with overflow area.
// Holds request and result structs, status and operation codes, default sizes.
// No dependencies.
package shto_pkg;

  localparam int unsigned PRIMARY_SLOTS_DEF  = 1024;
  localparam int unsigned OVERFLOW_SLOTS_DEF = 512;
  localparam int unsigned MAX_KEY_LEN_DEF    = 22;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } shto_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_LONG = 2'd3
  } shto_status_e;

  typedef struct packed {
    logic       op;
    logic [9:0] slot;
    logic [7:0] ch;
    logic       last_char;
  } shto_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  probes;
    logic [10:0] position;
  } shto_res_t;

  // Write strobes from the sequencer to the entry store.
  typedef struct packed {
    logic chr_we;
    logic len_we;
    logic used_we;
    logic used_wval;
  } shto_store_ctl_t;

endpackage

/* rtl/shto_store.sv */
// Entry store: entry text, entry lengths and primary used bits.
// Depends on shto_pkg for the write strobe struct.
module shto_store #(
  parameter int unsigned EW  = 11,
  parameter int unsigned LW  = 5,
  parameter int unsigned KLW = 5,
  parameter int unsigned PW  = 10,
  parameter int unsigned ENTRIES = 1536,
  parameter int unsigned PRIMARIES = 1024
) (
  input  logic                  clk_i,
  input  shto_pkg::shto_store_ctl_t ctl_i,
  input  logic [EW-1:0]         entry_i,
  input  logic [LW-1:0]         char_i,
  input  logic [7:0]            chr_wdata_i,
  input  logic [KLW-1:0]        len_wdata_i,
  input  logic [PW-1:0]         used_addr_i,
  output logic [7:0]            chr_rdata_o,
  output logic [KLW-1:0]        len_rdata_o,
  output logic                  used_rdata_o
);

  logic [7:0]     chr_mem  [ENTRIES << LW];
  logic [KLW-1:0] len_mem  [ENTRIES];
  logic           used_mem [PRIMARIES];

  always_ff @(posedge clk_i) begin
    if (ctl_i.chr_we) begin
      chr_mem[{entry_i, char_i}] <= chr_wdata_i;
    end
    chr_rdata_o <= chr_mem[{entry_i, char_i}];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.len_we) begin
      len_mem[entry_i] <= len_wdata_i;
    end
    len_rdata_o <= len_mem[entry_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.used_we) begin
      used_mem[used_addr_i] <= ctl_i.used_wval;
    end
    used_rdata_o <= used_mem[used_addr_i];
  end

endmodule

/* rtl/string_hash_table_overflow.sv */
// Top level of the string hash table with a shared overflow area.
// Depends on shto_pkg and shto_store.
//
//  channel | ports                      | handshake
//  --------+----------------------------+-----------------------------------
//  request | start, busy, req_i         | taken when start high, busy low
//  result  | res_valid_o, res_o         | one cycle strobe, cannot be held
//
// A character request that does not end the key is buffered and the block
// stays idle. A final request passes the slot check with one subtract per cycle
// while the slot is out of range, reads and checks the used bit, then an insert
// copies one character per cycle, while a lookup reads and checks each compared
// length and each compared character and steps to each next overflow entry on
// the entry store's single port. An over-long key is answered at once.
// After reset the block is busy while it clears the primary used bits, one per
// cycle. The receiver cannot stall results.
module string_hash_table_overflow #(
  parameter int unsigned PRIMARY_SLOTS  = shto_pkg::PRIMARY_SLOTS_DEF,
  parameter int unsigned OVERFLOW_SLOTS = shto_pkg::OVERFLOW_SLOTS_DEF,
  parameter int unsigned MAX_KEY_LEN    = shto_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  shto_pkg::shto_req_t req_i,
  output logic                res_valid_o,
  output shto_pkg::shto_res_t res_o
);

  localparam int unsigned Entries = PRIMARY_SLOTS + OVERFLOW_SLOTS;
  localparam int unsigned EW  = $clog2(Entries);
  localparam int unsigned LW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int unsigned KLW = $clog2(MAX_KEY_LEN + 1);
  localparam int unsigned PW  = $clog2(PRIMARY_SLOTS);
  localparam int unsigned OW  = $clog2(OVERFLOW_SLOTS + 1);
  localparam int unsigned BW  = $clog2(OVERFLOW_SLOTS + 2);
  localparam int unsigned SW  = (PW > 10) ? PW + 1 : 11;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MOD, S_USED_RD, S_USED_CK, S_COPY,
    S_LEN_RD, S_LEN_CK, S_CHR_RD, S_CHR_CK, S_NEXT
  } state_e;

  state_e          state_q;
  logic [7:0]      buf_q [MAX_KEY_LEN];
  logic [KLW-1:0]  klen_q;
  logic            exceeded_q;
  logic            op_q;
  logic [9:0]      slot_q;
  logic [EW-1:0]   entry_q;
  logic [LW-1:0]   idx_q;
  logic [OW-1:0]   ovf_q;
  logic [OW-1:0]   scan_q;
  logic [BW-1:0]   probes_q;
  logic [PW-1:0]   clr_q;
  logic            res_valid_q;
  shto_pkg::shto_res_t res_q;

  shto_pkg::shto_store_ctl_t ctl;
  logic [7:0]      chr_rdata;
  logic [KLW-1:0]  len_rdata;
  logic            used_rdata;
  logic [PW-1:0]   used_addr;
  logic            last_idx;

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign last_idx    = ((KLW'(idx_q) + KLW'(1)) == klen_q);

  // The used port sweeps during the clearing pass and follows the slot after.
  assign used_addr = (state_q == S_CLR) ? clr_q : PW'(slot_q);

  always_comb begin
    ctl.chr_we    = (state_q == S_COPY);
    ctl.len_we    = (state_q == S_COPY);
    ctl.used_we   = (state_q == S_CLR) ||
                    ((state_q == S_COPY) && last_idx && (entry_q < EW'(PRIMARY_SLOTS)));
    ctl.used_wval = (state_q != S_CLR);
  end

  shto_store #(
    .EW(EW), .LW(LW), .KLW(KLW), .PW(PW),
    .ENTRIES(Entries), .PRIMARIES(PRIMARY_SLOTS)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .entry_i      (entry_q),
    .char_i       (idx_q),
    .chr_wdata_i  (buf_q[idx_q]),
    .len_wdata_i  (klen_q),
    .used_addr_i  (used_addr),
    .chr_rdata_o  (chr_rdata),
    .len_rdata_o  (len_rdata),
    .used_rdata_o (used_rdata)
  );

  // Key buffer: written one character per accepted request while the key fits.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && start && (klen_q < KLW'(MAX_KEY_LEN))) begin
      buf_q[klen_q[LW-1:0]] <= req_i.ch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      klen_q      <= '0;
      exceeded_q  <= 1'b0;
      ovf_q       <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      op_q        <= 1'b0;
      slot_q      <= '0;
      entry_q     <= '0;
      idx_q       <= '0;
      scan_q      <= '0;
      probes_q    <= '0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + PW'(1);
          if (clr_q == PW'(PRIMARY_SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (klen_q < KLW'(MAX_KEY_LEN)) begin
              klen_q <= klen_q + KLW'(1);
            end else begin
              exceeded_q <= 1'b1;
            end
            if (req_i.last_char) begin
              op_q   <= req_i.op;
              slot_q <= req_i.slot;
              if (exceeded_q || (klen_q == KLW'(MAX_KEY_LEN))) begin
                // Over-long key: reject without touching the store.
                res_q       <= '{status: shto_pkg::ST_LONG, probes: '0, position: '0};
                res_valid_q <= 1'b1;
                klen_q      <= '0;
                exceeded_q  <= 1'b0;
              end else begin
                state_q <= S_MOD;
              end
            end
          end
        end
        S_MOD: begin
          if (SW'(slot_q) >= SW'(PRIMARY_SLOTS)) begin
            slot_q <= 10'(SW'(slot_q) - SW'(PRIMARY_SLOTS));
          end else begin
            state_q <= S_USED_RD;
          end
        end
        S_USED_RD: state_q <= S_USED_CK;
        S_USED_CK: begin
          idx_q <= '0;
          if (op_q == shto_pkg::OP_INSERT) begin
            if (!used_rdata) begin
              entry_q <= EW'(slot_q);
              state_q <= S_COPY;
            end else if (ovf_q < OW'(OVERFLOW_SLOTS)) begin
              entry_q <= EW'(PRIMARY_SLOTS) + EW'(ovf_q);
              ovf_q   <= ovf_q + OW'(1);
              state_q <= S_COPY;
            end else begin
              res_q       <= '{status: shto_pkg::ST_FULL, probes: '0, position: '0};
              res_valid_q <= 1'b1;
              klen_q      <= '0;
              state_q     <= S_IDLE;
            end
          end else if (!used_rdata) begin
            res_q       <= '{status: shto_pkg::ST_MISS, probes: '0, position: '0};
            res_valid_q <= 1'b1;
            klen_q      <= '0;
            state_q     <= S_IDLE;
          end else begin
            entry_q  <= EW'(slot_q);
            probes_q <= BW'(1);
            scan_q   <= '0;
            state_q  <= S_LEN_RD;
          end
        end
        S_COPY: begin
          idx_q <= idx_q + LW'(1);
          if (last_idx) begin
            res_q       <= '{status: shto_pkg::ST_OK, probes: '0, position: 11'(entry_q)};
            res_valid_q <= 1'b1;
            klen_q      <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_LEN_RD: state_q <= S_LEN_CK;
        S_LEN_CK: begin
          idx_q <= '0;
          state_q <= (len_rdata == klen_q) ? S_CHR_RD : S_NEXT;
        end
        S_CHR_RD: state_q <= S_CHR_CK;
        S_CHR_CK: begin
          if (chr_rdata != buf_q[idx_q]) begin
            state_q <= S_NEXT;
          end else if (last_idx) begin
            res_q       <= '{status: shto_pkg::ST_OK, probes: 10'(probes_q),
                             position: 11'(entry_q)};
            res_valid_q <= 1'b1;
            klen_q      <= '0;
            state_q     <= S_IDLE;
          end else begin
            idx_q   <= idx_q + LW'(1);
            state_q <= S_CHR_RD;
          end
        end
        S_NEXT: begin
          // Overflow entries fill in order, so the fill count marks the end.
          if (scan_q >= ovf_q) begin
            res_q       <= '{status: shto_pkg::ST_MISS, probes: 10'(probes_q),
                             position: '0};
            res_valid_q <= 1'b1;
            klen_q      <= '0;
            state_q     <= S_IDLE;
          end else begin
            entry_q  <= EW'(PRIMARY_SLOTS) + EW'(scan_q);
            scan_q   <= scan_q + OW'(1);
            probes_q <= probes_q + BW'(1);
            state_q  <= S_LEN_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A result whose status is not OK never carries a position.
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status != shto_pkg::ST_OK) |-> (res_o.position == '0))
    else $error("position set on a failed request");

  // Overflow full is reported only when every overflow entry is taken.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == shto_pkg::ST_FULL) |-> (ovf_q == OW'(OVERFLOW_SLOTS)))
    else $error("overflow full reported with free entries");

  // The lookup scan never walks past the filled overflow entries.
  a_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_q <= ovf_q) && (ovf_q <= OW'(OVERFLOW_SLOTS)))
    else $error("overflow scan or fill count out of range");

endmodule
